/* rtl/esc_pkg.sv */
// ----------------------------------------------------------------------------
// esc_pkg
// Shared constants, types and the month length table for the epoch seconds
// to UTC calendar unit.
// ----------------------------------------------------------------------------
package esc_pkg;

    localparam logic [16:0] SecsPerDay  = 17'd86400;
    localparam logic [11:0] SecsPerHour = 12'd3600;
    localparam logic [5:0]  SecsPerMin  = 6'd60;

    // Reciprocals for the odd factors: 675 (day after a shift by 7),
    // 225 (hour after a shift by 4) and 15 (minute after a shift by 2).
    // They are rounded up with scale shifts of 35, 21 and 14 bits.
    localparam logic [25:0] DayRecip   = 26'd50903317;
    localparam logic [13:0] HourRecip  = 14'd9321;
    localparam logic [10:0] MinRecip   = 11'd1093;

    // The year counters start at 1970.
    localparam logic [7:0] BaseYear    = 8'd70;
    localparam logic [1:0] BaseMod4    = 2'd2;
    localparam logic [6:0] BaseMod100  = 7'd70;
    localparam logic [8:0] BaseMod400  = 9'd370;
    localparam logic [6:0] LastMod100  = 7'd99;
    localparam logic [8:0] LastMod400  = 9'd399;

    localparam logic [8:0] LeapYearLen = 9'd366;
    localparam logic [8:0] YearLen     = 9'd365;

    localparam logic [3:0] MonthFeb    = 4'd1;
    localparam logic [3:0] MonthDec    = 4'd11;

    typedef struct packed {
        logic load_in;
        logic day_div;
        logic sod_sub;
        logic hr_div;
        logic min_sub;
        logic min_div;
        logic yr_step;
        logic mo_init;
        logic mo_step;
        logic publish;
    } t_cmd;

    typedef struct packed {
        logic yr_fit;
        logic mo_fit;
    } t_sts;

    function automatic logic [4:0] month_len(input logic [3:0] month, input logic leap);
        logic [4:0] len;
        begin
            case (month)
                4'd0:    len = 5'd31;
                4'd1:    len = leap ? 5'd29 : 5'd28;
                4'd2:    len = 5'd31;
                4'd3:    len = 5'd30;
                4'd4:    len = 5'd31;
                4'd5:    len = 5'd30;
                4'd6:    len = 5'd31;
                4'd7:    len = 5'd31;
                4'd8:    len = 5'd30;
                4'd9:    len = 5'd31;
                4'd10:   len = 5'd30;
                4'd11:   len = 5'd31;
                default: len = 5'd31;
            endcase
            return len;
        end
    endfunction

endpackage

/* rtl/epoch_seconds_to_utc_calendar_unit.sv */
// One item is converted at a time: a new one is accepted only while idle. The
// unit loads the seconds, divides them into days, splits the time of day, then
// walks up to 136 whole years, one year per cycle, and up to 11 whole months.
// A waiting result blocks only the publish of the next item; reset (synchronous,
// active low) returns the controller to idle and drops any output not yet taken.
// ----------------------------------------------------------------------------
// epoch_seconds_to_utc_calendar_unit
// Converts unsigned seconds since 1970-01-01 UTC into a calendar breakdown.
// ----------------------------------------------------------------------------
module epoch_seconds_to_utc_calendar_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [31:0] i_epoch_seconds,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [5:0]  o_second_of_minute,
    output logic [5:0]  o_minute_of_hour,
    output logic [4:0]  o_hour_of_day,
    output logic [7:0]  o_years_since_1900,
    output logic [8:0]  o_day_of_year,
    output logic [3:0]  o_month_index,
    output logic [4:0]  o_day_of_month
);

    esc_pkg::t_cmd cmd;
    esc_pkg::t_sts sts;

    esc_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_valid),
        .o_stall (o_stall),
        .o_valid (o_valid),
        .i_stall (i_stall),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    esc_dp u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_sts              (sts),
        .i_epoch_seconds    (i_epoch_seconds),
        .o_second_of_minute (o_second_of_minute),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_hour_of_day      (o_hour_of_day),
        .o_years_since_1900 (o_years_since_1900),
        .o_day_of_year      (o_day_of_year),
        .o_month_index      (o_month_index),
        .o_day_of_month     (o_day_of_month)
    );

endmodule

/* rtl/esc_dp.sv */
// ----------------------------------------------------------------------------
// esc_dp
// Datapath: reciprocal multipliers for the day and time of day split, year
// and month subtraction counters, and the result register.
// ----------------------------------------------------------------------------
module esc_dp (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  esc_pkg::t_cmd i_cmd,
    output esc_pkg::t_sts o_sts,
    input  logic [31:0]   i_epoch_seconds,
    output logic [5:0]    o_second_of_minute,
    output logic [5:0]    o_minute_of_hour,
    output logic [4:0]    o_hour_of_day,
    output logic [7:0]    o_years_since_1900,
    output logic [8:0]    o_day_of_year,
    output logic [3:0]    o_month_index,
    output logic [4:0]    o_day_of_month
);

    logic [31:0] r_in;
    logic [15:0] r_days;
    logic [16:0] r_sod;
    logic [4:0]  r_hour;
    logic [11:0] r_msec;
    logic [5:0]  r_min;
    logic [7:0]  r_yr;
    logic [1:0]  r_mod4;
    logic [6:0]  r_mod100;
    logic [8:0]  r_mod400;
    logic [8:0]  r_yday;
    logic [3:0]  r_month;

    logic [5:0]  r_out_sec;
    logic [5:0]  r_out_min;
    logic [4:0]  r_out_hour;
    logic [7:0]  r_out_yr;
    logic [8:0]  r_out_yday;
    logic [3:0]  r_out_month;
    logic [4:0]  r_out_mday;

    logic [50:0] day_prod;
    logic [31:0] day_base;
    logic [31:0] sod_full;
    logic [26:0] hr_prod;
    logic [16:0] hr_base;
    logic [16:0] msec_full;
    logic [20:0] min_prod;
    logic [11:0] min_base;
    logic [11:0] sec_full;
    logic        leap;
    logic [8:0]  ylen;
    logic [4:0]  mlen;

    // Each divisor is a power of two times an odd factor. The rounded-up
    // reciprocal of the odd factor gives the exact quotient over the whole
    // range of the shifted operand, and the remainder follows by subtraction.
    assign day_prod  = r_in[31:7] * esc_pkg::DayRecip;
    assign day_base  = r_days * esc_pkg::SecsPerDay;
    assign sod_full  = r_in - day_base;
    assign hr_prod   = r_sod[16:4] * esc_pkg::HourRecip;
    assign hr_base   = r_hour * esc_pkg::SecsPerHour;
    assign msec_full = r_sod - hr_base;
    assign min_prod  = r_msec[11:2] * esc_pkg::MinRecip;
    assign min_base  = r_min * esc_pkg::SecsPerMin;
    assign sec_full  = r_msec - min_base;

    assign leap = ((r_mod4 == 2'd0) && (r_mod100 != 7'd0)) || (r_mod400 == 9'd0);
    assign ylen = leap ? esc_pkg::LeapYearLen : esc_pkg::YearLen;
    assign mlen = esc_pkg::month_len(r_month, leap);

    assign o_sts.yr_fit = (r_days < {7'd0, ylen});
    assign o_sts.mo_fit = (r_days < {11'd0, mlen});

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_in <= i_epoch_seconds;
        end

        if (i_cmd.day_div) begin
            r_days <= day_prod[50:35];
        end else if (i_cmd.yr_step) begin
            r_days <= r_days - {7'd0, ylen};
        end else if (i_cmd.mo_step) begin
            r_days <= r_days - {11'd0, mlen};
        end

        if (i_cmd.sod_sub) begin
            r_sod <= sod_full[16:0];
        end

        if (i_cmd.hr_div) begin
            r_hour <= hr_prod[25:21];
        end

        if (i_cmd.min_sub) begin
            r_msec <= msec_full[11:0];
        end

        if (i_cmd.min_div) begin
            r_min <= min_prod[19:14];
        end

        if (i_cmd.mo_init) begin
            r_yday <= r_days[8:0];
        end

        if (i_cmd.publish) begin
            r_out_sec   <= sec_full[5:0];
            r_out_min   <= r_min;
            r_out_hour  <= r_hour;
            r_out_yr    <= r_yr;
            r_out_yday  <= r_yday;
            r_out_month <= r_month;
            r_out_mday  <= r_days[4:0] + 5'd1;
        end
    end

    // Year and month counters are reset so that their range checks hold
    // from the first cycle.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_yr     <= esc_pkg::BaseYear;
            r_mod4   <= esc_pkg::BaseMod4;
            r_mod100 <= esc_pkg::BaseMod100;
            r_mod400 <= esc_pkg::BaseMod400;
            r_month  <= 4'd0;
        end else begin
            if (i_cmd.day_div) begin
                r_yr     <= esc_pkg::BaseYear;
                r_mod4   <= esc_pkg::BaseMod4;
                r_mod100 <= esc_pkg::BaseMod100;
                r_mod400 <= esc_pkg::BaseMod400;
            end else if (i_cmd.yr_step) begin
                r_yr     <= r_yr + 8'd1;
                r_mod4   <= r_mod4 + 2'd1;
                r_mod100 <= (r_mod100 == esc_pkg::LastMod100) ? 7'd0 : r_mod100 + 7'd1;
                r_mod400 <= (r_mod400 == esc_pkg::LastMod400) ? 9'd0 : r_mod400 + 9'd1;
            end

            if (i_cmd.mo_init) begin
                r_month <= 4'd0;
            end else if (i_cmd.mo_step) begin
                r_month <= r_month + 4'd1;
            end
        end
    end

    assign o_second_of_minute = r_out_sec;
    assign o_minute_of_hour   = r_out_min;
    assign o_hour_of_day      = r_out_hour;
    assign o_years_since_1900 = r_out_yr;
    assign o_day_of_year      = r_out_yday;
    assign o_month_index      = r_out_month;
    assign o_day_of_month     = r_out_mday;

    // A 32-bit input never reaches past 2106.
    a_year_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_yr <= 8'd206)
        else $error("year counter ran past 2106");

    // The month walk stops inside December because the day of year fits the year.
    a_month_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.mo_step |-> r_month < esc_pkg::MonthDec)
        else $error("month walk ran past December");

    // February only gets a 29th day in leap years.
    a_feb_len: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_month == esc_pkg::MonthFeb && !leap) |-> mlen == 5'd28)
        else $error("February length wrong in a common year");

endmodule

/* rtl/esc_ctrl.sv */
// ----------------------------------------------------------------------------
// esc_ctrl
// Controller: sequences the day division, the hour and minute divisions,
// the year and month walks, and hands the result to the output register.
// ----------------------------------------------------------------------------
module esc_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_valid,
    output logic          o_stall,
    output logic          o_valid,
    input  logic          i_stall,
    input  esc_pkg::t_sts i_sts,
    output esc_pkg::t_cmd o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DAY,
        S_SOD,
        S_HR,
        S_MINSUB,
        S_MIN,
        S_YEAR,
        S_MONTH
    } t_state;

    t_state      r_state;
    t_state      n_state;
    logic        r_o_valid;
    logic        n_o_valid;
    logic        r_fin;
    logic        n_fin;

    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        o_cmd   = '0;

        case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state = S_DAY;
                end
            end
            S_DAY: begin
                o_cmd.day_div = 1'b1;
                n_state = S_SOD;
            end
            S_SOD: begin
                o_cmd.sod_sub = 1'b1;
                n_state = S_HR;
            end
            S_HR: begin
                o_cmd.hr_div = 1'b1;
                n_state = S_MINSUB;
            end
            S_MINSUB: begin
                o_cmd.min_sub = 1'b1;
                n_state = S_MIN;
            end
            S_MIN: begin
                o_cmd.min_div = 1'b1;
                n_state = S_YEAR;
            end
            S_YEAR: begin
                if (i_sts.yr_fit) begin
                    o_cmd.mo_init = 1'b1;
                    n_state = S_MONTH;
                end else begin
                    o_cmd.yr_step = 1'b1;
                end
            end
            S_MONTH: begin
                // Once the month is found the result waits here until the
                // output register is free.
                if (!r_fin && !i_sts.mo_fit) begin
                    o_cmd.mo_step = 1'b1;
                end else begin
                    n_fin = 1'b1;
                    if (!r_o_valid || !i_stall) begin
                        o_cmd.publish = 1'b1;
                        n_fin   = 1'b0;
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        n_o_valid = o_cmd.publish | (r_o_valid & i_stall);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_o_valid <= 1'b0;
            r_fin     <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_o_valid <= n_o_valid;
            r_fin     <= n_fin;
        end
    end

    assign o_stall = (r_state != S_IDLE);
    assign o_valid = r_o_valid;

    // An accepted item always starts the day division.
    a_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && !o_stall) |=> (r_state == S_DAY))
        else $error("accepted item did not start the day division");

    // A new result never overwrites one that is still waiting.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.publish |-> (!r_o_valid || !i_stall))
        else $error("result published over a waiting item");

    // The minute division is always followed by the year walk.
    a_min_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_MIN) |=> (r_state == S_YEAR))
        else $error("minute division did not hand over to the year walk");

endmodule

/* test/tb_top.sv */
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for epoch_seconds_to_utc_calendar_unit. It sends
// directed items at day, month, year and century boundaries, then random
// seconds weighted toward day edges and the long year walk near 2106. Every
// accepted item is converted by a local calendar predictor, and each result
// is checked, in order, against the oldest prediction.
// ----------------------------------------------------------------------------
module tb_top;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned RandomItems = 1700;
    localparam int unsigned CycleLimit  = 1200000;
    localparam int unsigned TailCycles  = 200;
    localparam int unsigned MaxIdle     = 14;
    localparam int unsigned ReportLimit = 10;

    typedef struct packed {
        logic [5:0] second_of_minute;
        logic [5:0] minute_of_hour;
        logic [4:0] hour_of_day;
        logic [7:0] years_since_1900;
        logic [8:0] day_of_year;
        logic [3:0] month_index;
        logic [4:0] day_of_month;
    } t_calendar;

    class calendar_scoreboard;
        t_calendar   expected_q[$];
        logic [31:0] source_q[$];
        int unsigned failures;
        int unsigned month_lengths[12];

        function new();
            month_lengths = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
            failures = 0;
        endfunction

        function bit year_is_leap(input int unsigned year);
            return ((year % 4) == 0 && (year % 100) != 0) || (year % 400) == 0;
        endfunction

        function t_calendar convert_seconds(input logic [31:0] secs);
            t_calendar   cal;
            int unsigned days_left;
            int unsigned secs_of_day;
            int unsigned year;
            int unsigned month;
            int unsigned span;
            days_left   = secs / 86400;
            secs_of_day = secs % 86400;
            year        = 1970;
            span        = year_is_leap(year) ? 366 : 365;
            while (days_left >= span) begin
                days_left -= span;
                year++;
                span = year_is_leap(year) ? 366 : 365;
            end
            cal.day_of_year = days_left[8:0];
            month = 0;
            while (month < 12) begin
                span = month_lengths[month];
                if (month == 1 && year_is_leap(year)) begin
                    span = 29;
                end
                if (days_left < span) begin
                    break;
                end
                days_left -= span;
                month++;
            end
            cal.second_of_minute = 6'(secs_of_day % 60);
            cal.minute_of_hour   = 6'((secs_of_day / 60) % 60);
            cal.hour_of_day      = 5'(secs_of_day / 3600);
            cal.years_since_1900 = 8'(year - 1900);
            cal.month_index      = 4'(month);
            cal.day_of_month     = 5'(days_left + 1);
            return cal;
        endfunction

        function string show_calendar(input t_calendar cal);
            return $sformatf("%0d:%0d:%0d y%0d yd%0d m%0d d%0d",
                             cal.hour_of_day, cal.minute_of_hour, cal.second_of_minute,
                             cal.years_since_1900, cal.day_of_year, cal.month_index,
                             cal.day_of_month);
        endfunction

        function void note_input(input logic [31:0] secs);
            expected_q.push_back(convert_seconds(secs));
            source_q.push_back(secs);
        endfunction

        function void check_result(input t_calendar got);
            t_calendar   want;
            logic [31:0] secs;
            if (expected_q.size() == 0) begin
                failures++;
                if (failures <= ReportLimit) begin
                    $display("unexpected result with nothing pending: %s",
                             show_calendar(got));
                end
                return;
            end
            want = expected_q.pop_front();
            secs = source_q.pop_front();
            if (got !== want) begin
                failures++;
                if (failures <= ReportLimit) begin
                    $display("mismatch for %0d s: expected %s, got %s",
                             secs, show_calendar(want), show_calendar(got));
                end
            end
        endfunction

        function int unsigned pending();
            return expected_q.size();
        endfunction
    endclass

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_stall;
    logic [31:0] i_epoch_seconds;
    logic        o_valid;
    logic        i_stall;
    logic [5:0]  o_second_of_minute;
    logic [5:0]  o_minute_of_hour;
    logic [4:0]  o_hour_of_day;
    logic [7:0]  o_years_since_1900;
    logic [8:0]  o_day_of_year;
    logic [3:0]  o_month_index;
    logic [4:0]  o_day_of_month;

    // While set, neither side inserts idle cycles.
    bit steady;

    calendar_scoreboard calendar_sb;

    epoch_seconds_to_utc_calendar_unit dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_stall            (o_stall),
        .i_epoch_seconds    (i_epoch_seconds),
        .o_valid            (o_valid),
        .i_stall            (i_stall),
        .o_second_of_minute (o_second_of_minute),
        .o_minute_of_hour   (o_minute_of_hour),
        .o_hour_of_day      (o_hour_of_day),
        .o_years_since_1900 (o_years_since_1900),
        .o_day_of_year      (o_day_of_year),
        .o_month_index      (o_month_index),
        .o_day_of_month     (o_day_of_month)
    );

    initial begin
        i_clk = 1'b0;
    end

    always #1 i_clk = ~i_clk;

    initial begin
        i_rst_n         = 1'b0;
        i_valid         = 1'b0;
        i_stall         = 1'b0;
        i_epoch_seconds = '0;
        steady          = 1'b0;
        calendar_sb     = new();
    end

    // Called at a falling edge; returns at the falling edge after acceptance.
    task automatic send_seconds(input logic [31:0] secs);
        int unsigned gap;
        gap = steady ? 0 : $urandom_range(0, MaxIdle);
        if (gap > 0) begin
            i_valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_valid         <= 1'b1;
        i_epoch_seconds <= secs;
        forever begin
            @(posedge i_clk);
            if (!o_stall) begin
                break;
            end
        end
        calendar_sb.note_input(secs);
        @(negedge i_clk);
    endtask

    function automatic logic [31:0] random_seconds();
        int unsigned day_index;
        logic [31:0] secs;
        case ($urandom_range(0, 3))
            0: secs = $urandom();
            // Late dates make the year walk as long as it gets.
            1: secs = $urandom_range(32'hFFFF_FFFF, 32'hEC00_0000);
            2: begin
                day_index = $urandom_range(0, 49709);
                case ($urandom_range(0, 3))
                    0:       secs = day_index * 86400;
                    1:       secs = day_index * 86400 + 86399;
                    2:       secs = day_index * 86400 + 43200;
                    default: secs = day_index * 86400 + $urandom_range(0, 86399);
                endcase
            end
            default: secs = $urandom_range(0, 100000000);
        endcase
        return secs;
    endfunction

    // Result side: a random stall before each item, then take it.
    initial begin
        int unsigned hold;
        t_calendar   got;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        @(negedge i_clk);
        forever begin
            hold = steady ? 0 : $urandom_range(0, MaxIdle);
            if (hold > 0) begin
                i_stall <= 1'b1;
                repeat (hold) @(negedge i_clk);
            end
            i_stall <= 1'b0;
            forever begin
                @(posedge i_clk);
                if (o_valid) begin
                    break;
                end
            end
            got.second_of_minute = o_second_of_minute;
            got.minute_of_hour   = o_minute_of_hour;
            got.hour_of_day      = o_hour_of_day;
            got.years_since_1900 = o_years_since_1900;
            got.day_of_year      = o_day_of_year;
            got.month_index      = o_month_index;
            got.day_of_month     = o_day_of_month;
            calendar_sb.check_result(got);
            @(negedge i_clk);
        end
    end

    initial begin
        int unsigned cycle_count;
        cycle_count = 0;
        while (cycle_count < CycleLimit) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("epoch_seconds_to_utc_calendar_unit regression: fail");
        $finish;
    end

    initial begin
        logic [31:0] boundary_secs[$];
        boundary_secs = '{
            32'd0,          32'd59,         32'd60,         32'd3599,
            32'd3600,       32'd86399,      32'd86400,      32'd31535999,
            32'd31536000,   32'd68169600,   32'd94694399,   32'd94694400,
            32'd951782400,  32'd4102444799, 32'd4107542399, 32'd4107542400,
            32'd4133980799, 32'd4133980800, 32'h7FFF_FFFF,  32'h8000_0000,
            32'hAAAA_AAAA,  32'h5555_5555,  32'hFFFF_FFFE,  32'hFFFF_FFFF
        };
        repeat (9) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // Boundaries: day and year edges, leap days, 2000 as a leap
        // century, 2100 as a common year, and the top of the 32-bit range.
        foreach (boundary_secs[k]) begin
            send_seconds(boundary_secs[k]);
        end

        for (int unsigned n = 0; n < RandomItems; n++) begin
            steady = ((n / 150) % 4) == 2;
            send_seconds(random_seconds());
        end
        i_valid <= 1'b0;
        steady  = 1'b0;

        while (calendar_sb.pending() != 0) @(posedge i_clk);
        repeat (TailCycles) @(posedge i_clk);

        if (calendar_sb.failures == 0 && calendar_sb.pending() == 0) begin
            $display("epoch_seconds_to_utc_calendar_unit regression: pass");
        end else begin
            $display("epoch_seconds_to_utc_calendar_unit regression: fail");
        end
        $finish;
    end

endmodule
